/* rtl/core/pfba_pkg.sv */
`timescale 1ns / 1ps

package pfba_pkg;

    // Field widths
    localparam int KIND_W        = 2;
    localparam int PAGE_W        = 10;
    localparam int STATUS_W      = 2;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = 3;

    // Allocate only hands out pages the page field can express: 1024 pages, 128 bytes
    localparam int SUM_BYTES = 128;
    localparam int SUM_IDX_W = 7;
    localparam int GROUPS    = 16;
    localparam int GRP_W     = 4;

    localparam logic [BITS_PER_BYTE-1:0] FULL_BYTE = 8'hFF;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // Sequencer to free-byte search
    typedef struct packed {
        logic                 grp_load;
        logic                 upd_en;
        logic [SUM_IDX_W-1:0] upd_idx;
        logic                 upd_full;
    } srch_ctrl_t;

    // Free-byte search to sequencer
    typedef struct packed {
        logic                 grp_any;
        logic [SUM_IDX_W-1:0] byte_idx;
    } srch_stat_t;

endpackage

/* rtl/core/pfba_channels.sv */
`timescale 1ns / 1ps

interface pfba_req_if import pfba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] frame_num;

    modport source (output valid, kind, frame_num, input ready);
    modport sink   (input valid, kind, frame_num, output ready);
endinterface

interface pfba_rsp_if import pfba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PAGE_W-1:0]   result_page;
    logic [STATUS_W-1:0] status;

    modport source (output valid, result_page, status, input ready);
    modport sink   (input valid, result_page, status, output ready);
endinterface

/* rtl/core/pfba_bitmap_ram.sv */
`timescale 1ns / 1ps

module pfba_bitmap_ram import pfba_pkg::*; #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [BITS_PER_BYTE-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [BITS_PER_BYTE-1:0] rdata
);

    logic [BITS_PER_BYTE-1:0] mem [DEPTH];

    // Write one byte
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/pfba_free_search.sv */
`timescale 1ns / 1ps

module pfba_free_search import pfba_pkg::*; #(
    parameter int ALLOC_BYTES = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  srch_ctrl_t ctrl,
    output srch_stat_t stat
);

    logic [SUM_BYTES-1:0] full_reg;
    logic [SUM_BYTES-1:0] eff_full;
    logic [GROUPS-1:0]    grp_full;
    logic [GRP_W-1:0]     grp_reg;
    logic [GRP_W-1:0]     grp_first;
    logic                 grp_hit;
    logic [BITS_PER_BYTE-1:0] row;
    logic [BIT_W-1:0]     row_first;

    // Bytes the allocator may not hand out count as full
    always_comb
    begin
        for (int i = 0; i < SUM_BYTES; i++)
        begin
            eff_full[i] = full_reg[i] | (i >= ALLOC_BYTES);
        end
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_full[g] = &eff_full[g*BITS_PER_BYTE +: BITS_PER_BYTE];
        end
    end

    // First group with room
    always_comb
    begin
        grp_hit   = 1'b0;
        grp_first = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (!grp_full[g])
            begin
                grp_hit   = 1'b1;
                grp_first = GRP_W'(g);
            end
        end
    end

    // First byte with room inside the held group
    always_comb
    begin
        row       = eff_full[{grp_reg, 3'b000} +: BITS_PER_BYTE];
        row_first = '0;
        for (int j = BITS_PER_BYTE - 1; j >= 0; j--)
        begin
            if (!row[j])
            begin
                row_first = BIT_W'(j);
            end
        end
    end

    assign stat.grp_any  = grp_hit;
    assign stat.byte_idx = {grp_reg, row_first};

    // Track full bytes, hold the chosen group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (ctrl.upd_en)
        begin
            full_reg[ctrl.upd_idx] <= ctrl.upd_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grp_load)
        begin
            grp_reg <= grp_first;
        end
    end

endmodule

/* rtl/core/page_frame_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps

// First-fit page frame allocator over a bitmap of BITMAP_BYTES bytes, one bit per
// page, held in a single-port-read RAM. After reset the block clears every byte of
// the RAM and keeps req.ready low meanwhile. One request is worked at a time:
// allocate runs group search, byte search, RAM read, then modify and write; free
// and mark run a RAM read-modify-write; an allocate that finds no room, and
// out-of-range or unused kinds, go straight to the result. The sequencer returns to
// idle on the edge that loads the result; requests are accepted only in idle, so a
// new request waits until the last one is through. A 128-bit
// summary of full bytes, searched as 16 groups of 8, finds the first byte with
// room. The next request is accepted while a result still waits on rsp; its own
// result then holds the sequencer until the waiting beat is taken.
module page_frame_bitmap_allocator_unit import pfba_pkg::*; #(
    parameter int BITMAP_BYTES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    pfba_req_if.sink      req,
    pfba_rsp_if.source    rsp
);

    localparam int ADDR_W      = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int TOTAL_PAGES = BITMAP_BYTES * BITS_PER_BYTE;
    localparam int ALLOC_BYTES = (BITMAP_BYTES < SUM_BYTES) ? BITMAP_BYTES : SUM_BYTES;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BYTE,
        S_READ,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [SUM_IDX_W-1:0]  byte_idx_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [PAGE_W-1:0]     res_page_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [PAGE_W-1:0]     out_page_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                     accept;
    logic                     in_range;
    logic                     is_alloc;
    logic [BIT_W-1:0]         free_bit;
    logic [BITS_PER_BYTE-1:0] upd_mask;
    logic [BITS_PER_BYTE-1:0] new_byte;
    logic [BITS_PER_BYTE-1:0] ram_rdata;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [BITS_PER_BYTE-1:0] ram_wdata;
    srch_ctrl_t               srch_ctrl;
    srch_stat_t               srch_stat;

    assign req.ready       = (state_reg == S_IDLE);
    assign accept          = req.valid && req.ready;
    assign in_range        = ({22'd0, req.frame_num} < 32'(TOTAL_PAGES));
    assign is_alloc        = (kind_reg == KIND_ALLOC);

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_page = out_page_reg;
    assign rsp.status      = out_status_reg;

    // Lowest clear bit of the byte just read
    always_comb
    begin
        free_bit = '0;
        for (int j = BITS_PER_BYTE - 1; j >= 0; j--)
        begin
            if (!ram_rdata[j])
            begin
                free_bit = BIT_W'(j);
            end
        end
    end

    // Modify the byte: set for allocate and mark, clear for free
    always_comb
    begin
        upd_mask = BITS_PER_BYTE'(1) << (is_alloc ? free_bit : bit_reg);
        if (kind_reg == KIND_FREE)
        begin
            new_byte = ram_rdata & ~upd_mask;
        end
        else
        begin
            new_byte = ram_rdata | upd_mask;
        end
    end

    // Drive the search summary and the RAM from the sequencer state
    always_comb
    begin
        srch_ctrl.grp_load = accept && (req.kind == KIND_ALLOC);
        srch_ctrl.upd_en   = (state_reg == S_UPDATE);
        srch_ctrl.upd_idx  = byte_idx_reg;
        srch_ctrl.upd_full = (new_byte == FULL_BYTE);

        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_UPDATE);
        ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : ADDR_W'(byte_idx_reg);
        ram_wdata = (state_reg == S_CLEAR) ? '0 : new_byte;
    end

    pfba_bitmap_ram #(
        .DEPTH  (BITMAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == S_READ),
        .raddr (ADDR_W'(byte_idx_reg)),
        .rdata (ram_rdata)
    );

    pfba_free_search #(
        .ALLOC_BYTES (ALLOC_BYTES)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (srch_ctrl),
        .stat  (srch_stat)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result beat once taken; the result state reloads it itself
            if (rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(BITMAP_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg       <= req.kind;
                        bit_reg        <= req.frame_num[BIT_W-1:0];
                        byte_idx_reg   <= req.frame_num[PAGE_W-1:BIT_W];
                        res_page_reg   <= req.frame_num;
                        res_status_reg <= STATUS_OK;
                        if (req.kind == KIND_ALLOC)
                        begin
                            if (srch_stat.grp_any)
                            begin
                                state_reg <= S_BYTE;
                            end
                            else
                            begin
                                res_page_reg   <= '0;
                                res_status_reg <= STATUS_FULL;
                                state_reg      <= S_DONE;
                            end
                        end
                        else if ((req.kind == KIND_FREE || req.kind == KIND_MARK)
                                 && in_range)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            res_status_reg <= STATUS_RANGE;
                            state_reg      <= S_DONE;
                        end
                    end
                end

                S_BYTE:
                begin
                    byte_idx_reg <= srch_stat.byte_idx;
                    state_reg    <= S_READ;
                end

                S_READ:
                begin
                    state_reg <= S_UPDATE;
                end

                S_UPDATE:
                begin
                    if (is_alloc)
                    begin
                        res_page_reg <= {byte_idx_reg, free_bit};
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_page_reg   <= res_page_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/page_frame_bitmap_allocator_unit_tb.sv */
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_unit_tb;
    import pfba_pkg::*;

    localparam int TB_BYTES     = 128;
    localparam int FRAME_PAGES  = TB_BYTES * BITS_PER_BYTE;
    localparam int ALLOC_PAGES  = (FRAME_PAGES < 1024) ? FRAME_PAGES : 1024;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_AT     = 700;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 600000;

    // Request kind that the block does not implement
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [STATUS_W-1:0] status;
    } page_result_t;

    // Shadow of the frame bitmap and the queue of replies it predicts
    class frame_scoreboard;
        logic [BITS_PER_BYTE-1:0] frames [TB_BYTES];
        page_result_t             replies_q [$];
        int errors;
        int used_pages;
        int n_alloc_ok;
        int n_full;
        int n_free;
        int n_mark;
        int n_range;
        int n_checked;

        function new();
            foreach (frames[i])
                frames[i] = '0;
            errors     = 0;
            used_pages = 0;
            n_alloc_ok = 0;
            n_full     = 0;
            n_free     = 0;
            n_mark     = 0;
            n_range    = 0;
            n_checked  = 0;
        endfunction

        function int pending();
            return replies_q.size();
        endfunction

        function bit page_used(int pg);
            return frames[pg / BITS_PER_BYTE][pg % BITS_PER_BYTE];
        endfunction

        // Apply one accepted request to the shadow bitmap and queue its reply
        function void note_request(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] pg);
            page_result_t exp_reply;
            bit           found;
            int           b;
            int           j;
            int           cand;
            exp_reply.page   = pg;
            exp_reply.status = STATUS_OK;
            found            = 1'b0;
            if (kind == KIND_ALLOC)
            begin
                // first byte with room, lowest clear bit, within the page field
                for (b = 0; b < TB_BYTES && !found && b * BITS_PER_BYTE < ALLOC_PAGES;
                     b++)
                begin
                    if (frames[b] != FULL_BYTE)
                    begin
                        for (j = 0; j < BITS_PER_BYTE && !found; j++)
                        begin
                            cand = b * BITS_PER_BYTE + j;
                            if (cand < ALLOC_PAGES && !frames[b][j])
                            begin
                                found = 1'b1;
                                frames[b][j] = 1'b1;
                                used_pages++;
                                exp_reply.page = cand[PAGE_W-1:0];
                            end
                        end
                    end
                end
                if (found)
                begin
                    n_alloc_ok++;
                end
                else
                begin
                    exp_reply.page   = '0;
                    exp_reply.status = STATUS_FULL;
                    n_full++;
                end
            end
            else if (kind == KIND_FREE || kind == KIND_MARK)
            begin
                if (int'(pg) >= FRAME_PAGES)
                begin
                    exp_reply.status = STATUS_RANGE;
                    n_range++;
                end
                else
                begin
                    if (kind == KIND_MARK)
                    begin
                        if (!page_used(pg))
                            used_pages++;
                        frames[pg / BITS_PER_BYTE][pg % BITS_PER_BYTE] = 1'b1;
                        n_mark++;
                    end
                    else
                    begin
                        if (page_used(pg))
                            used_pages--;
                        frames[pg / BITS_PER_BYTE][pg % BITS_PER_BYTE] = 1'b0;
                        n_free++;
                    end
                end
            end
            else
            begin
                exp_reply.status = STATUS_RANGE;
                n_range++;
            end
            replies_q.push_back(exp_reply);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one reply beat against the oldest prediction
        task check_result(logic [PAGE_W-1:0] pg, logic [STATUS_W-1:0] st);
            page_result_t exp_reply;
            if (replies_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected reply page=%0d status=%0d", pg, st));
            end
            else
            begin
                exp_reply = replies_q.pop_front();
                n_checked++;
                if (pg !== exp_reply.page)
                    report_mismatch($sformatf("result_page got %0d want %0d",
                                              pg, exp_reply.page));
                if (st !== exp_reply.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              st, exp_reply.status));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    pfba_req_if req_ch ();
    pfba_rsp_if rsp_ch ();

    page_frame_bitmap_allocator_unit #(
        .BITMAP_BYTES (TB_BYTES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    frame_scoreboard sb = new();

    int sent_count  = 0;
    int cycle_count = 0;
    bit calm_phase  = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short idle gaps, a few long ones, none in calm phases
    function automatic int pick_idle();
        int r;
        if (calm_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [PAGE_W-1:0] any_page();
        return PAGE_W'($urandom_range(0, 1023));
    endfunction

    // Drop valid and hold until every predicted reply has arrived
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Offer one request beat and hold it until accepted
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [PAGE_W-1:0] pg);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.kind      <= kind;
        req_ch.frame_num <= pg;
        req_ch.valid     <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(kind, pg);
        sent_count++;
        if ($urandom_range(0, 99) == 0)
            calm_phase = !calm_phase;
        if (sent_count == DRAIN_AT)
            wait_drained();
    endtask

    // Short directed opening: field extremes, every kind, first-fit reuse
    task automatic run_directed();
        send_request(KIND_ALLOC, 10'h3FF);
        send_request(KIND_ALLOC, 10'h000);
        send_request(KIND_ALLOC, 10'h2AA);
        send_request(KIND_FREE, 10'd1);
        send_request(KIND_ALLOC, 10'h155);
        send_request(KIND_MARK, 10'd1023);
        send_request(KIND_FREE, 10'd1023);
        send_request(KIND_MARK, 10'd3);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_MARK, 10'd5);
        send_request(KIND_MARK, 10'd6);
        send_request(KIND_MARK, 10'd7);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_FREE, 10'd0);
        send_request(KIND_ALLOC, 10'd0);
        send_request(KIND_UNUSED, 10'h000);
        send_request(KIND_UNUSED, 10'h3FF);
        send_request(KIND_UNUSED, 10'h2AA);
        send_request(KIND_FREE, 10'd500);
        send_request(KIND_MARK, 10'd2);
        send_request(KIND_MARK, 10'd512);
        send_request(KIND_FREE, 10'd512);
        send_request(KIND_FREE, 10'd0);
    endtask

    // Fill the whole bitmap with allocations and scattered marks, then hit the full case
    task automatic run_fill();
        int r;
        while (sb.used_pages < ALLOC_PAGES && sent_count < 3000)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_request(KIND_ALLOC, any_page());
            else if (r < 95)
                send_request(KIND_MARK, any_page());
            else if (r < 98)
                send_request(KIND_FREE, any_page());
            else
                send_request(KIND_UNUSED, any_page());
        end
        repeat ($urandom_range(2, 4)) send_request(KIND_ALLOC, any_page());
    endtask

    // Free a few pages of a nearly full bitmap, then allocate past them into the full case
    task automatic run_refill_rounds(input int stop_at);
        int k;
        int r;
        while (sent_count < stop_at)
        begin
            k = $urandom_range(1, 6);
            repeat (k)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_request(KIND_FREE, any_page());
                else if (r < 95)
                    send_request(KIND_MARK, any_page());
                else
                    send_request(KIND_UNUSED, any_page());
            end
            repeat (k + $urandom_range(0, 2)) send_request(KIND_ALLOC, any_page());
            // occasional noise burst of any kind
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 5))
                    send_request(KIND_W'($urandom_range(0, 3)), any_page());
        end
    endtask

    // Reply side: random stalls, one long hold-off once enough requests went in
    initial
    begin
        int stall;
        bit held;
        held         = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_idle();
            if (!held && sent_count >= HOLD_AT)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            sb.check_result(rsp_ch.result_page, rsp_ch.status);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d replies outstanding",
                 cycle_count, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        int directed_end;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_ALLOC;
        req_ch.frame_num <= '0;
        rst_n            <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();
        directed_end = sent_count;
        run_fill();
        run_refill_rounds(directed_end + RANDOM_ITEMS);

        // Drain and let the block settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests in %0d cycles, %0d replies checked",
                 sent_count, cycle_count, sb.n_checked);
        $display("  allocations %0d, full replies %0d, frees %0d, marks %0d, rejected %0d",
                 sb.n_alloc_ok, sb.n_full, sb.n_free, sb.n_mark, sb.n_range);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d replies missing", sb.errors, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
